FILE: hw/rtl/edc_pkg.sv
// Shared types and constants for the Euclidean distance core.
// Used by the core, its add/subtract unit and its checker; no dependencies.
`timescale 1ns / 1ps

package edc_pkg;

    // Default build parameters.
    localparam int MAX_DIM_DEF    = 1024;
    localparam int COORD_BITS_DEF = 16;

    // Running sum is 43 bits; the root search works on it padded to 44 bits.
    localparam int SUM_BITS   = 43;
    localparam int RAD_W      = 44;
    localparam int DIST_W     = 21;
    localparam int ROOT_W     = RAD_W / 2;
    localparam int REM_W      = ROOT_W + 2;
    localparam int SQRT_STEPS = RAD_W / 2;
    localparam int OUT_TDATA_W = ((DIST_W + 7) / 8) * 8;

    localparam logic [SUM_BITS-1:0] SUM_MAX  = {SUM_BITS{1'b1}};
    localparam logic [DIST_W-1:0]   DIST_MAX = {DIST_W{1'b1}};

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_SQRT,
        ST_HOLD
    } edc_state_t;

    // Operation request to the shared add/subtract unit.
    typedef struct packed {
        logic sub;
    } edc_op_t;

endpackage

FILE: hw/rtl/edc_alu.sv
// Shared add/subtract unit of the Euclidean distance core.
// Depends on edc_pkg for the operation struct.
`timescale 1ns / 1ps

module edc_alu
    import edc_pkg::*;
#(
    parameter int ADD_W = 46
)
(
    input  edc_op_t            op,
    input  logic [ADD_W-1:0]   op_a,
    input  logic [ADD_W-1:0]   op_b,
    output logic [ADD_W-1:0]   res
);

    logic [ADD_W-1:0] b_eff;

    // Two's complement subtraction by inverting b and adding one.
    always_comb
    begin
        b_eff = op.sub ? ~op_b : op_b;
        res   = op_a + b_eff + ADD_W'(op.sub);
    end

endmodule

FILE: hw/rtl/euclidean_distance_core.sv
// Euclidean distance core: one coordinate pair per input word, floor square root at vector end.
// After a pair is accepted the input stays closed while the shift-add squarer adds |a - b|^2
// into the sum; a last pair then runs the root search, then loads the result register
// once the previous result has been taken.
// A new input word is taken only once this work is done; the single shared adder serves both.
// Reset (rst_n, asynchronous, active low) clears the sum, dim count and the sat and valid flags.
`timescale 1ns / 1ps

module euclidean_distance_core
    import edc_pkg::*;
#(
    parameter int MAX_DIM    = MAX_DIM_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int IN_W      = ((2 * COORD_BITS + 7) / 8) * 8
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    // Input words.
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [IN_W-1:0]         s_tdata,   // coord_a, coord_b (from bit 0 up)
    input  logic                    s_tlast,   // last_dim
    // Result words.
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [OUT_TDATA_W-1:0]  m_tdata,   // distance (from bit 0 up), zero padding
    output logic                    m_tuser    // overflowed
);

    localparam int SQ_W    = 2 * COORD_BITS;
    localparam int ADD_W   = ((SQ_W > RAD_W) ? SQ_W : RAD_W) + 2;
    localparam int DIM_W   = $clog2(MAX_DIM + 1);
    localparam int STEP_W  = $clog2(SQRT_STEPS);

    edc_state_t state_reg, state_next;

    logic [RAD_W-1:0]      sum_reg, sum_next;
    logic [DIM_W-1:0]      dim_count_reg, dim_count_next;
    logic                  sat_reg, sat_next;
    logic                  last_reg, last_next;
    logic [SQ_W-1:0]       mcand_reg, mcand_next;
    logic [COORD_BITS-1:0] mplier_reg, mplier_next;
    logic [REM_W-1:0]      rem_reg, rem_next;
    logic [ROOT_W-1:0]     root_reg, root_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic                  out_valid_reg, out_valid_next;
    logic [DIST_W-1:0]     dist_reg, dist_next;
    logic                  ovf_reg, ovf_next;

    logic                  in_accept;
    logic                  out_free;
    logic signed [COORD_BITS-1:0] coord_a;
    logic signed [COORD_BITS-1:0] coord_b;
    logic signed [COORD_BITS:0]   diff;
    logic [COORD_BITS:0]          diff_mag;

    edc_op_t               alu_op;
    logic [ADD_W-1:0]      alu_a;
    logic [ADD_W-1:0]      alu_b;
    logic [ADD_W-1:0]      alu_res;
    logic [1:0]            rad_top;
    logic                  trial_neg;

    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE);

    // Absolute difference of the incoming pair.
    always_comb
    begin
        coord_a  = s_tdata[COORD_BITS-1:0];
        coord_b  = s_tdata[2*COORD_BITS-1:COORD_BITS];
        diff     = {coord_b[COORD_BITS-1], coord_b} - {coord_a[COORD_BITS-1], coord_a};
        diff_mag = diff[COORD_BITS] ? -diff : diff;
    end

    // Operand selection for the shared adder.
    always_comb
    begin
        rad_top = sum_reg[RAD_W-1 -: 2];
        if (state_reg == ST_SQRT)
        begin
            alu_op.sub = 1'b1;
            alu_a      = ADD_W'({rem_reg, rad_top});
            alu_b      = ADD_W'({root_reg, 2'b01});
        end
        else
        begin
            alu_op.sub = 1'b0;
            alu_a      = ADD_W'(sum_reg);
            alu_b      = ADD_W'(mcand_reg);
        end
    end

    // A negative trial subtraction means the next root bit is zero.
    assign trial_neg = alu_res[ADD_W-1];

    edc_alu #(
        .ADD_W (ADD_W)
    ) u_alu (
        .op   (alu_op),
        .op_a (alu_a),
        .op_b (alu_b),
        .res  (alu_res)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (mplier_reg == '0)
                begin
                    state_next = last_reg ? ST_SQRT : ST_IDLE;
                end
            end
            ST_SQRT:
            begin
                if (step_reg == STEP_W'(SQRT_STEPS - 1))
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and output register updates.
    always_comb
    begin
        sum_next       = sum_reg;
        dim_count_next = dim_count_reg;
        sat_next       = sat_reg;
        last_next      = last_reg;
        mcand_next     = mcand_reg;
        mplier_next    = mplier_reg;
        rem_next       = rem_reg;
        root_next      = root_reg;
        step_next      = step_reg;
        dist_next      = dist_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    last_next = s_tlast;
                    rem_next  = '0;
                    root_next = '0;
                    step_next = '0;
                    if (dim_count_reg >= DIM_W'(MAX_DIM))
                    begin
                        // Too many dimensions: pin the sum at its maximum.
                        sat_next    = 1'b1;
                        sum_next    = RAD_W'(SUM_MAX);
                        mplier_next = '0;
                        mcand_next  = '0;
                    end
                    else
                    begin
                        dim_count_next = dim_count_reg + 1'b1;
                        mplier_next    = diff_mag[COORD_BITS-1:0];
                        mcand_next     = SQ_W'(diff_mag[COORD_BITS-1:0]);
                    end
                end
            end
            ST_MUL:
            begin
                // Shift-add squaring straight into the running sum.
                if (mplier_reg != '0)
                begin
                    mcand_next  = mcand_reg << 1;
                    mplier_next = mplier_reg >> 1;
                    if (mplier_reg[0])
                    begin
                        if (alu_res > ADD_W'(SUM_MAX))
                        begin
                            sat_next    = 1'b1;
                            sum_next    = RAD_W'(SUM_MAX);
                            mplier_next = '0;
                        end
                        else
                        begin
                            sum_next = alu_res[RAD_W-1:0];
                        end
                    end
                end
            end
            ST_SQRT:
            begin
                // One root digit per cycle; the radicand shifts out and leaves the sum zero.
                sum_next  = sum_reg << 2;
                step_next = step_reg + 1'b1;
                if (trial_neg)
                begin
                    rem_next  = {rem_reg[REM_W-3:0], rad_top};
                    root_next = {root_reg[ROOT_W-2:0], 1'b0};
                end
                else
                begin
                    rem_next  = alu_res[REM_W-1:0];
                    root_next = {root_reg[ROOT_W-2:0], 1'b1};
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    dist_next      = root_reg[ROOT_W-1] ? DIST_MAX : root_reg[DIST_W-1:0];
                    ovf_next       = sat_reg;
                    out_valid_next = 1'b1;
                    dim_count_next = '0;
                    sat_next       = 1'b0;
                end
            end
            default:
            begin
                sum_next = sum_reg;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sum_reg       <= '0;
            dim_count_reg <= '0;
            sat_reg       <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            dim_count_reg <= dim_count_next;
            sat_reg       <= sat_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        last_reg   <= last_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        rem_reg    <= rem_next;
        root_reg   <= root_next;
        dist_reg   <= dist_next;
        ovf_reg    <= ovf_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_W'(dist_reg);
    assign m_tuser  = ovf_reg;

endmodule

FILE: hw/rtl/edc_checker.sv
// Port-level checks for the Euclidean distance core, bound to its top level.
// Depends on edc_pkg and euclidean_distance_core.
`timescale 1ns / 1ps

module edc_checker
    import edc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int IN_W      = ((2 * COORD_BITS + 7) / 8) * 8
)
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic [IN_W-1:0]        s_tdata,
    input logic                   s_tlast,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata,
    input logic                   m_tuser
);

    // An offered input word holds still until it is taken.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tlast))
        else $error("input word changed while waiting");

    // A waiting result word holds still until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // The padding above the distance is always zero.
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[OUT_TDATA_W-1:DIST_W] == '0))
        else $error("result padding bits not zero");

    // One word at a time: the input closes right after an accept.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after an accepted word");

    // A new result only appears at the end of a busy period.
    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without preceding work");

endmodule

bind euclidean_distance_core edc_checker #(
    .COORD_BITS (COORD_BITS)
) u_edc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

FILE: tb/sv/tb_euclidean_distance_core.sv
// Self-checking testbench for euclidean_distance_core: directed pairs, then random vector pairs.
// A local integer square-root predictor supplies expected words; depends only on edc_pkg and the core.
`timescale 1ns / 1ps

module tb_euclidean_distance_core;
    import edc_pkg::*;

    localparam int MAX_DIM      = MAX_DIM_DEF;
    localparam int COORD_BITS   = COORD_BITS_DEF;
    localparam int IN_W         = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam int RANDOM_ITEMS = 300;
    localparam int LONG_HOLD    = 300;
    localparam int SETTLE       = 60;
    localparam int ROW_COUNT    = 18;

    localparam logic signed [COORD_BITS-1:0] COORD_MIN = 16'sh8000;
    localparam logic signed [COORD_BITS-1:0] COORD_MAX = 16'sh7FFF;
    localparam longint unsigned SUM_LIMIT = (64'd1 << SUM_BITS) - 64'd1;
    localparam longint unsigned DIST_LIMIT = (64'd1 << DIST_W) - 64'd1;

    // One expected result word.
    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              ovf;
    } dist_result_t;

    // One directed row: reps copies of a pair, the last one optionally marked last_dim.
    typedef struct {
        logic signed [COORD_BITS-1:0] coord_a;
        logic signed [COORD_BITS-1:0] coord_b;
        int                           reps;
        bit                           last;
        bit                           known;
        logic [DIST_W-1:0]            distance;
        bit                           ovf;
    } pair_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_W-1:0]        s_tdata;   // coord_a, coord_b (from bit 0 up)
    logic                   s_tlast;   // last_dim
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;   // distance (from bit 0 up), zero padding
    logic                   m_tuser;   // overflowed

    // Predictor state: running sum, pairs in this vector, saturation seen.
    longint unsigned acc_sum;
    int              acc_dims;
    bit              acc_sat;

    dist_result_t pending_distances[$];
    int           fault_count;
    int           burst_left;
    bit           rx_hold_req;

    pair_row_t directed_rows [ROW_COUNT] = '{
        // Zero distance, and both coordinate extremes in each order.
        '{16'sd0, 16'sd0, 1, 1, 1, 21'd0, 1'b0},
        '{COORD_MAX, COORD_MIN, 1, 1, 1, 21'd65535, 1'b0},
        '{COORD_MIN, COORD_MAX, 1, 1, 1, 21'd65535, 1'b0},
        '{-16'sd1, 16'sd0, 1, 1, 1, 21'd1, 1'b0},
        // A two-dimensional 3-4-5 triangle.
        '{16'sd3, 16'sd0, 1, 0, 0, 21'd0, 1'b0},
        '{16'sd0, 16'sd4, 1, 1, 1, 21'd5, 1'b0},
        // Identical points over four dimensions.
        '{16'sd7, 16'sd7, 3, 0, 0, 21'd0, 1'b0},
        '{16'sd7, 16'sd7, 1, 1, 1, 21'd0, 1'b0},
        '{COORD_MAX, COORD_MIN, 4, 1, 1, 21'd131070, 1'b0},
        // Mixed bit patterns, left to the predictor.
        '{16'sh1234, 16'shFA99, 1, 0, 0, 21'd0, 1'b0},
        '{16'sh5A5A, 16'shA5A5, 1, 0, 0, 21'd0, 1'b0},
        '{16'sh00FF, 16'shFF00, 1, 1, 0, 21'd0, 1'b0},
        '{16'sh8001, 16'sh0001, 1, 1, 0, 21'd0, 1'b0},
        // A full-length vector of extreme pairs plus one pair too many saturates
        // the sum and clamps the root.
        '{COORD_MAX, COORD_MIN, MAX_DIM + 1, 1, 1, {DIST_W{1'b1}}, 1'b1},
        // State must be clear again after a saturated vector.
        '{16'sd1, 16'sd1, 1, 1, 1, 21'd0, 1'b0},
        '{16'sd5, 16'sd2, 2, 1, 0, 21'd0, 1'b0},
        '{COORD_MIN, COORD_MIN, 1, 0, 0, 21'd0, 1'b0},
        '{16'sh7FFE, 16'sh8002, 1, 1, 0, 21'd0, 1'b0}
    };

    euclidean_distance_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Clock generation.
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Floor square root, built one result bit at a time from the top.
    function automatic longint unsigned floor_root(input longint unsigned x);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int i = 22; i >= 0; i--)
        begin
            t = r | (64'd1 << i);
            if (t * t <= x)
                r = t;
        end
        return r;
    endfunction

    // Fold one accepted pair into the running sum; on the last pair, produce the distance.
    task automatic fold_pair(input logic signed [COORD_BITS-1:0] a,
                             input logic signed [COORD_BITS-1:0] b,
                             input bit last, output bit produced, output dist_result_t res);
        longint          diff;
        longint unsigned sq;
        longint unsigned root;
        diff = longint'(a) - longint'(b);
        if (diff < 0)
            diff = -diff;
        sq = longint'(diff) * longint'(diff);
        if (acc_dims >= MAX_DIM)
        begin
            acc_sat = 1'b1;
            acc_sum = SUM_LIMIT;
        end
        else
        begin
            acc_dims++;
            if (sq > SUM_LIMIT - acc_sum)
            begin
                acc_sat = 1'b1;
                acc_sum = SUM_LIMIT;
            end
            else
                acc_sum += sq;
        end
        produced = last;
        res = '0;
        if (last)
        begin
            root = floor_root(acc_sum);
            if (root > DIST_LIMIT)
                root = DIST_LIMIT;
            res.distance = root[DIST_W-1:0];
            res.ovf = acc_sat;
            acc_sum = 0;
            acc_dims = 0;
            acc_sat = 1'b0;
        end
    endtask

    // Random coordinate, weighted toward the extremes and small values.
    function automatic logic signed [COORD_BITS-1:0] rand_coord();
        case ($urandom_range(0, 7))
            0: return COORD_MIN;
            1: return COORD_MAX;
            2, 3: return COORD_BITS'($urandom_range(0, 32) - 16);
            default: return COORD_BITS'($urandom);
        endcase
    endfunction

    // Offer one pair word in bursts with random gaps; record its expectation once accepted.
    task automatic send_pair(input logic signed [COORD_BITS-1:0] a,
                             input logic signed [COORD_BITS-1:0] b,
                             input bit last, input bit known, input dist_result_t typed);
        int           gap;
        bit           produced;
        dist_result_t res;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= IN_W'({b, a});
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        fold_pair(a, b, last, produced, res);
        if (produced)
            pending_distances = {pending_distances, (known ? typed : res)};
    endtask

    // Stop offering and wait until every expected word has come back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_distances.size() != 0)
            @(posedge clk);
    endtask

    task automatic report_fault(input string what, input dist_result_t want);
        fault_count++;
        if (fault_count <= 10)
            $display("%0t: %s: expected distance %0d overflow %0d, got distance %0d overflow %0d",
                     $time, what, want.distance, want.ovf, m_tdata, m_tuser);
    endtask

    // Receiver: segments of steady or random readiness, plus one long hold-off on request.
    initial
    begin
        int mode;
        int seg_len;
        m_tready = 1'b0;
        forever
        begin
            mode = $urandom_range(0, 3);
            seg_len = $urandom_range(5, 60);
            repeat (seg_len)
            begin
                if (rx_hold_req)
                begin
                    m_tready <= 1'b0;
                    repeat (LONG_HOLD) @(posedge clk);
                    rx_hold_req = 1'b0;
                end
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 99) < 50);
                    2: m_tready <= ($urandom_range(0, 99) < 80);
                    default: m_tready <= ($urandom_range(0, 99) < 25);
                endcase
                @(posedge clk);
            end
        end
    end

    // Result checker: every accepted word is compared with the oldest expectation.
    always @(posedge clk)
    begin
        dist_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_distances.size() == 0)
                report_fault("unexpected result word", '0);
            else
            begin
                want = pending_distances.pop_front();
                if (m_tdata != {{(OUT_TDATA_W - DIST_W){1'b0}}, want.distance} ||
                    m_tuser != want.ovf)
                    report_fault("result mismatch", want);
            end
        end
    end

    // Run limit.
    initial
    begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Main sequence: reset, directed rows, random vectors, then the final check.
    initial
    begin
        int           sent;
        int           vec_len;
        bit           hold_done;
        bit           drain_done;
        dist_result_t typed;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        rx_hold_req = 1'b0;
        fault_count = 0;
        burst_left = 0;
        acc_sum = 0;
        acc_dims = 0;
        acc_sat = 1'b0;
        sent = 0;
        hold_done = 1'b0;
        drain_done = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows.
        foreach (directed_rows[r])
        begin
            typed.distance = directed_rows[r].distance;
            typed.ovf = directed_rows[r].ovf;
            for (int k = 0; k < directed_rows[r].reps; k++)
                send_pair(directed_rows[r].coord_a, directed_rows[r].coord_b,
                          directed_rows[r].last && (k == directed_rows[r].reps - 1),
                          directed_rows[r].known, typed);
        end
        drain_results();

        // Random vector pairs, mostly short with an occasional longer one.
        while (sent < RANDOM_ITEMS)
        begin
            vec_len = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            for (int k = 0; k < vec_len; k++)
                send_pair(rand_coord(), rand_coord(), k == vec_len - 1, 1'b0, '0);
            sent += vec_len;
            if (!hold_done && sent >= RANDOM_ITEMS / 3)
            begin
                rx_hold_req = 1'b1;
                hold_done = 1'b1;
            end
            if (!drain_done && sent >= (2 * RANDOM_ITEMS) / 3)
            begin
                drain_results();
                drain_done = 1'b1;
            end
        end

        drain_results();
        repeat (SETTLE) @(posedge clk);
        if (fault_count == 0 && pending_distances.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/edc_pkg.sv
hw/rtl/edc_alu.sv
hw/rtl/euclidean_distance_core.sv
hw/rtl/edc_checker.sv
tb/sv/tb_euclidean_distance_core.sv
